### hdl/plt_pkg.sv
// Shared types and constants of the port learning table.
package plt_pkg;

   localparam int PORT_W  = 16;
   localparam int PROTO_W = 8;
   localparam int SLOT_W  = 5;
   localparam int COUNT_W = 6;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
   localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   // Register index, taken from paddr bit 2.
   localparam logic REG_BACKEND_PRESENT = 1'b0;
   localparam logic REG_LEARN_ENABLE    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic pass;
      logic scan_start;
      logic scan_run;
      logic hit_done;
      logic write_entry;
      logic push;
   } plt_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic eligible;
      logic hit;
      logic scan_done;
      logic out_free;
   } plt_status_type;

endpackage

### hdl/plt_chan_if.sv
// Valid/ready channel interfaces for request and response beats.
interface plt_req_if import plt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [PROTO_W-1:0] ip_protocol;
   logic [PORT_W-1:0]  dest_port;
   logic               from_wireless;

   modport source (output valid, output operation, output ip_protocol,
                   output dest_port, output from_wireless, input ready);
   modport sink   (input valid, input operation, input ip_protocol,
                   input dest_port, input from_wireless, output ready);
endinterface

interface plt_rsp_if import plt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               learned;
   logic               already_known;
   logic [SLOT_W-1:0]  written_slot;
   logic [COUNT_W-1:0] fill_count;

   modport source (output valid, output learned, output already_known,
                   output written_slot, output fill_count, input ready);
   modport sink   (input valid, input learned, input already_known,
                   input written_slot, input fill_count, output ready);
endinterface

### hdl/plt_csr.sv
// APB-style configuration registers of the port learning table.
module plt_csr import plt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output logic               backend_present,
   output logic               learn_enable
);

   logic backend_ff;
   logic backend_in;
   logic enable_ff;
   logic enable_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      backend_in = backend_ff;
      enable_in  = enable_ff;
      prdata     = '0;
      case (paddr[2])
         REG_BACKEND_PRESENT: begin
            prdata = PDATA_W'(backend_ff);
            if (wr_en) begin
               backend_in = pwdata[0];
            end
         end
         REG_LEARN_ENABLE: begin
            prdata = PDATA_W'(enable_ff);
            if (wr_en) begin
               enable_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backend_ff <= 1'b0;
         enable_ff  <= 1'b0;
      end else begin
         backend_ff <= backend_in;
         enable_ff  <= enable_in;
      end
   end

   assign backend_present = backend_ff;
   assign learn_enable    = enable_ff;

endmodule

### hdl/plt_ctrl.sv
// Controller state machine that sequences check, scan, write and response.
module plt_ctrl import plt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  plt_status_type status,
   output plt_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_clear) begin
               cmd.clear = 1'b1;
               state_in  = ST_RESP;
            end else if (!status.eligible) begin
               cmd.pass = 1'b1;
               state_in = ST_RESP;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.hit_done = 1'b1;
               state_in     = ST_RESP;
            end else if (status.scan_done) begin
               state_in = ST_WRITE;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/plt_dp.sv
// Datapath of the port learning table: item latch, entry memory, scan and result.
module plt_dp import plt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  plt_cmd_type        cmd,
   output plt_status_type     status,
   input  logic               backend_present,
   input  logic               learn_enable,
   input  logic               req_operation,
   input  logic [PROTO_W-1:0] req_ip_protocol,
   input  logic [PORT_W-1:0]  req_dest_port,
   input  logic               req_from_wireless,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_learned,
   output logic               rsp_already_known,
   output logic [SLOT_W-1:0]  rsp_written_slot,
   output logic [COUNT_W-1:0] rsp_fill_count
);

   localparam int PTR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [PORT_W:0] entry_mem [TABLE_DEPTH];

   logic               op_ff;
   logic [PROTO_W-1:0] proto_ff;
   logic [PORT_W-1:0]  port_ff;
   logic               wireless_ff;

   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] idx_ff;
   logic             cmp_vld_ff;
   logic [PORT_W:0]  rd_data_ff;

   logic               res_learned_ff;
   logic               res_known_ff;
   logic [SLOT_W-1:0]  res_slot_ff;
   logic [COUNT_W-1:0] res_count_ff;

   logic               rsp_valid_ff;
   logic               out_learned_ff;
   logic               out_known_ff;
   logic [SLOT_W-1:0]  out_slot_ff;
   logic [COUNT_W-1:0] out_count_ff;

   logic issue;
   logic mem_re;
   logic is_udp;

   assign issue  = idx_ff < count_ff;
   assign mem_re = cmd.scan_run && issue;
   assign is_udp = (proto_ff == PROTO_UDP);

   assign ptr_in   = (ptr_ff == PTR_W'(TABLE_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
   assign count_in = (count_ff < CNT_W'(TABLE_DEPTH)) ? CNT_W'(ptr_ff) + CNT_W'(1)
                                                       : count_ff;

   assign status.is_clear  = (op_ff == OP_CLEAR);
   assign status.eligible  = backend_present && learn_enable && wireless_ff &&
                             ((proto_ff == PROTO_TCP) || is_udp);
   assign status.hit       = cmp_vld_ff && (rd_data_ff[PORT_W-1:0] == port_ff);
   assign status.scan_done = !issue && !cmp_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         entry_mem[ptr_ff] <= {is_udp, port_ff};
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[idx_ff[PTR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_operation;
         proto_ff    <= req_ip_protocol;
         port_ff     <= req_dest_port;
         wireless_ff <= req_from_wireless;
      end
      if (cmd.clear || cmd.pass || cmd.hit_done || cmd.write_entry) begin
         res_learned_ff <= cmd.write_entry;
         res_known_ff   <= cmd.hit_done;
         res_slot_ff    <= cmd.write_entry ? SLOT_W'(ptr_ff) : '0;
         res_count_ff   <= cmd.clear       ? '0 :
                           cmd.write_entry ? COUNT_W'(count_in) : COUNT_W'(count_ff);
      end
      if (cmd.push) begin
         out_learned_ff <= res_learned_ff;
         out_known_ff   <= res_known_ff;
         out_slot_ff    <= res_slot_ff;
         out_count_ff   <= res_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            ptr_ff   <= '0;
            count_ff <= '0;
         end else if (cmd.write_entry) begin
            ptr_ff   <= ptr_in;
            count_ff <= count_in;
         end
         if (cmd.scan_start) begin
            idx_ff     <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            cmp_vld_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_learned       = out_learned_ff;
   assign rsp_already_known = out_known_ff;
   assign rsp_written_slot  = out_slot_ff;
   assign rsp_fill_count    = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count exceeds table depth");

   a_ptr_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff < CNT_W'(TABLE_DEPTH)) |-> (CNT_W'(ptr_ff) == count_ff))
      else $error("write pointer does not follow fill count before the table is full");

   a_write_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |=> (count_ff != '0))
      else $error("fill count is zero after an entry was written");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while a beat is pending");

endmodule

### hdl/port_learning_table_top.sv
// Top level of the port learning table.
// The block learns destination ports of TCP and UDP packets into a table of TABLE_DEPTH
// entries, one item at a time. A clear or a packet that is not learned goes from accept
// to response beat without a scan; a learned or known packet adds a scan of the filled
// entries through the single read port of the entry memory, one entry per cycle, and
// the response beat can be held further by a response stall.
// A new request beat is taken while the previous response beat still waits.
// Registers: backend_present at byte address 0, learn_enable at byte address 4, bit 0 each.
module port_learning_table_top import plt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   plt_req_if.sink            req_bus,
   plt_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   plt_cmd_type    cmd;
   plt_status_type status;
   logic           backend_present;
   logic           learn_enable;

   plt_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .backend_present (backend_present),
      .learn_enable    (learn_enable)
   );

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   plt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .backend_present   (backend_present),
      .learn_enable      (learn_enable),
      .req_operation     (req_bus.operation),
      .req_ip_protocol   (req_bus.ip_protocol),
      .req_dest_port     (req_bus.dest_port),
      .req_from_wireless (req_bus.from_wireless),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_learned       (rsp_bus.learned),
      .rsp_already_known (rsp_bus.already_known),
      .rsp_written_slot  (rsp_bus.written_slot),
      .rsp_fill_count    (rsp_bus.fill_count)
   );

endmodule
